// File: rtl/core/sip_pkg.sv
// constants shared by the segment intersection point datapath
// no dependencies
`timescale 1ns / 1ps

package sip_pkg;

  // width of the fixed point result coordinates
  localparam int OUT_W   = 24;
  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

endpackage

// File: rtl/core/segment_intersection_point.sv
// segment_intersection_point: bounding box and cross product straddle test on two segments,
// then the intersection point as signed fixed point (FRAC fraction bits), truncated toward zero.
// throughput: one request per cycle unless out_ready_i stalls the output, set by the
// one-bit-per-stage pipelined restoring divider.
// reset clears only the stage valid bits; the pipeline is empty and ready right after reset.
// depends on sip_pkg
`timescale 1ns / 1ps

module segment_intersection_point #(
  parameter int COORD_BITS = 16,
  parameter int FRAC       = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [COORD_BITS-1:0]      seg_a_start_x_i,
  input  logic signed [COORD_BITS-1:0]      seg_a_start_y_i,
  input  logic signed [COORD_BITS-1:0]      seg_a_end_x_i,
  input  logic signed [COORD_BITS-1:0]      seg_a_end_y_i,
  input  logic signed [COORD_BITS-1:0]      seg_b_start_x_i,
  input  logic signed [COORD_BITS-1:0]      seg_b_start_y_i,
  input  logic signed [COORD_BITS-1:0]      seg_b_end_x_i,
  input  logic signed [COORD_BITS-1:0]      seg_b_end_y_i,

  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic                              parallel_o,
  output logic signed [sip_pkg::OUT_W-1:0]  point_x_o,
  output logic signed [sip_pkg::OUT_W-1:0]  point_y_o
);

  import sip_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int DFW  = CW + 1;          // coordinate difference
  localparam int PW   = 2 * DFW;         // cross product term
  localparam int XW   = PW + 1;          // cross product
  localparam int MW   = 2 * CW + 1;      // magnitude of num and den
  localparam int HL   = CW + 1;          // low slice of |num| for the split multiply
  localparam int NPW  = MW + CW;         // |num| * |vec|
  localparam int QB   = CW + FRAC;       // quotient bits, one per divider stage
  localparam int DVW  = NPW + FRAC;      // dividend
  localparam int SW   = CW + FRAC + 2;   // signed point before saturation
  localparam int EW   = ((SW > OUT_W) ? SW : OUT_W) + 1;
  localparam int NST  = QB + 8;          // register stages
  localparam int ST_DIV0 = 5;
  localparam int ST_PA   = QB + 6;
  localparam int ST_PB   = QB + 7;

  // ---------------------------------------------------------------------------
  // stage valid bits and ready chain
  // ---------------------------------------------------------------------------
  logic [NST-1:0] vld_q;
  logic [NST:0]   rdy;

  assign rdy[NST] = out_ready_i;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = ~vld_q[k] | rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NST-1];

  // ---------------------------------------------------------------------------
  // stage 0: differences and bounding box test
  // ---------------------------------------------------------------------------
  logic signed [DFW-1:0] a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;
  logic                  box_rej;

  assign a1x = DFW'(seg_a_start_x_i);
  assign a1y = DFW'(seg_a_start_y_i);
  assign a2x = DFW'(seg_a_end_x_i);
  assign a2y = DFW'(seg_a_end_y_i);
  assign b1x = DFW'(seg_b_start_x_i);
  assign b1y = DFW'(seg_b_start_y_i);
  assign b2x = DFW'(seg_b_end_x_i);
  assign b2y = DFW'(seg_b_end_y_i);

  // max of one pair below min of the other means every element is below
  assign box_rej = ((b1x < a1x) && (b1x < a2x) && (b2x < a1x) && (b2x < a2x)) ||
                   ((a1x < b1x) && (a1x < b2x) && (a2x < b1x) && (a2x < b2x)) ||
                   ((b1y < a1y) && (b1y < a2y) && (b2y < a1y) && (b2y < a2y)) ||
                   ((a1y < b1y) && (a1y < b2y) && (a2y < b1y) && (a2y < b2y));

  logic signed [DFW-1:0] s0_vax_q, s0_vay_q, s0_vbx_q, s0_vby_q;
  logic signed [DFW-1:0] s0_e1x_q, s0_e1y_q, s0_e2x_q, s0_e2y_q;
  logic signed [DFW-1:0] s0_f1x_q, s0_f1y_q, s0_f2x_q, s0_f2y_q;
  logic                  s0_box_q;
  logic signed [CW-1:0]  s0_bx_q, s0_by_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s0_vax_q <= a2x - a1x;
      s0_vay_q <= a2y - a1y;
      s0_vbx_q <= b2x - b1x;
      s0_vby_q <= b2y - b1y;
      s0_e1x_q <= b1x - a1x;
      s0_e1y_q <= b1y - a1y;
      s0_e2x_q <= b2x - a1x;
      s0_e2y_q <= b2y - a1y;
      s0_f1x_q <= a1x - b1x;
      s0_f1y_q <= a1y - b1y;
      s0_f2x_q <= a2x - b1x;
      s0_f2y_q <= a2y - b1y;
      s0_box_q <= ~box_rej;
      s0_bx_q  <= seg_a_start_x_i;
      s0_by_q  <= seg_a_start_y_i;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: cross product terms
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0]  s1_pa0_q, s1_pa1_q, s1_pa2_q, s1_pa3_q;
  logic signed [PW-1:0]  s1_pb0_q, s1_pb1_q, s1_pb2_q, s1_pb3_q;
  logic signed [PW-1:0]  s1_pd0_q, s1_pd1_q;
  logic signed [DFW-1:0] s1_vax_q, s1_vay_q;
  logic                  s1_box_q;
  logic signed [CW-1:0]  s1_bx_q, s1_by_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s1_pa0_q <= PW'(s0_vax_q) * PW'(s0_e1y_q);
      s1_pa1_q <= PW'(s0_vay_q) * PW'(s0_e1x_q);
      s1_pa2_q <= PW'(s0_vax_q) * PW'(s0_e2y_q);
      s1_pa3_q <= PW'(s0_vay_q) * PW'(s0_e2x_q);
      s1_pb0_q <= PW'(s0_vbx_q) * PW'(s0_f1y_q);
      s1_pb1_q <= PW'(s0_vby_q) * PW'(s0_f1x_q);
      s1_pb2_q <= PW'(s0_vbx_q) * PW'(s0_f2y_q);
      s1_pb3_q <= PW'(s0_vby_q) * PW'(s0_f2x_q);
      s1_pd0_q <= PW'(s0_vax_q) * PW'(s0_vby_q);
      s1_pd1_q <= PW'(s0_vay_q) * PW'(s0_vbx_q);
      s1_vax_q <= s0_vax_q;
      s1_vay_q <= s0_vay_q;
      s1_box_q <= s0_box_q;
      s1_bx_q  <= s0_bx_q;
      s1_by_q  <= s0_by_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: cross products; the side of a1 against B doubles as the numerator
  // ---------------------------------------------------------------------------
  logic signed [XW-1:0]  s2_sb1_q, s2_sb2_q, s2_num_q, s2_sa2_q, s2_den_q;
  logic signed [DFW-1:0] s2_vax_q, s2_vay_q;
  logic                  s2_box_q;
  logic signed [CW-1:0]  s2_bx_q, s2_by_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s2_sb1_q <= XW'(s1_pa0_q) - XW'(s1_pa1_q);
      s2_sb2_q <= XW'(s1_pa2_q) - XW'(s1_pa3_q);
      s2_num_q <= XW'(s1_pb0_q) - XW'(s1_pb1_q);
      s2_sa2_q <= XW'(s1_pb2_q) - XW'(s1_pb3_q);
      s2_den_q <= XW'(s1_pd0_q) - XW'(s1_pd1_q);
      s2_vax_q <= s1_vax_q;
      s2_vay_q <= s1_vay_q;
      s2_box_q <= s1_box_q;
      s2_bx_q  <= s1_bx_q;
      s2_by_q  <= s1_by_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: straddle test, flags, magnitudes and quotient signs
  // ---------------------------------------------------------------------------
  logic              same_a, same_b, hit_c;
  logic [XW-1:0]     num_abs, den_abs;
  logic [DFW-1:0]    vax_abs, vay_abs;

  // both endpoints strictly on one side
  assign same_a = (!s2_sb1_q[XW-1] && (s2_sb1_q != '0) && !s2_sb2_q[XW-1] && (s2_sb2_q != '0)) ||
                  (s2_sb1_q[XW-1] && s2_sb2_q[XW-1]);
  assign same_b = (!s2_num_q[XW-1] && (s2_num_q != '0) && !s2_sa2_q[XW-1] && (s2_sa2_q != '0)) ||
                  (s2_num_q[XW-1] && s2_sa2_q[XW-1]);
  assign hit_c  = s2_box_q & ~same_a & ~same_b;

  assign num_abs = s2_num_q[XW-1] ? -s2_num_q : s2_num_q;
  assign den_abs = s2_den_q[XW-1] ? -s2_den_q : s2_den_q;
  assign vax_abs = s2_vax_q[DFW-1] ? -s2_vax_q : s2_vax_q;
  assign vay_abs = s2_vay_q[DFW-1] ? -s2_vay_q : s2_vay_q;

  logic [MW-1:0]        s3_num_q, s3_den_q;
  logic [CW-1:0]        s3_vx_q, s3_vy_q;
  logic                 s3_hit_q, s3_par_q, s3_negx_q, s3_negy_q;
  logic signed [CW-1:0] s3_bx_q, s3_by_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s3_num_q  <= num_abs[MW-1:0];
      s3_den_q  <= den_abs[MW-1:0];
      s3_vx_q   <= vax_abs[CW-1:0];
      s3_vy_q   <= vay_abs[CW-1:0];
      s3_hit_q  <= hit_c;
      s3_par_q  <= hit_c & (s2_den_q == '0);
      s3_negx_q <= s2_num_q[XW-1] ^ s2_den_q[XW-1] ^ s2_vax_q[DFW-1];
      s3_negy_q <= s2_num_q[XW-1] ^ s2_den_q[XW-1] ^ s2_vay_q[DFW-1];
      s3_bx_q   <= s2_bx_q;
      s3_by_q   <= s2_by_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: |num| * |vec| as two partial products per coordinate
  // ---------------------------------------------------------------------------
  logic [HL+CW-1:0]     s4_xlo_q, s4_ylo_q;
  logic [2*CW-1:0]      s4_xhi_q, s4_yhi_q;
  logic [MW-1:0]        s4_den_q;
  logic                 s4_hit_q, s4_par_q, s4_negx_q, s4_negy_q;
  logic signed [CW-1:0] s4_bx_q, s4_by_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      s4_xlo_q  <= (HL+CW)'(s3_num_q[HL-1:0]) * (HL+CW)'(s3_vx_q);
      s4_ylo_q  <= (HL+CW)'(s3_num_q[HL-1:0]) * (HL+CW)'(s3_vy_q);
      s4_xhi_q  <= (2*CW)'(s3_num_q[MW-1:HL]) * (2*CW)'(s3_vx_q);
      s4_yhi_q  <= (2*CW)'(s3_num_q[MW-1:HL]) * (2*CW)'(s3_vy_q);
      s4_den_q  <= s3_den_q;
      s4_hit_q  <= s3_hit_q;
      s4_par_q  <= s3_par_q;
      s4_negx_q <= s3_negx_q;
      s4_negy_q <= s3_negy_q;
      s4_bx_q   <= s3_bx_q;
      s4_by_q   <= s3_by_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5 and divider stages: restoring division, one quotient bit a stage
  // index 0 holds the loaded dividend, index j the state after step j
  // ---------------------------------------------------------------------------
  logic [NPW-1:0] nx, ny;
  logic [DVW-1:0] dvx, dvy;

  assign nx  = (NPW'(s4_xhi_q) << HL) + NPW'(s4_xlo_q);
  assign ny  = (NPW'(s4_yhi_q) << HL) + NPW'(s4_ylo_q);
  assign dvx = DVW'(nx) << FRAC;
  assign dvy = DVW'(ny) << FRAC;

  logic [MW-1:0]        dv_rx_q  [0:QB];
  logic [QB-1:0]        dv_lx_q  [0:QB];
  logic [MW-1:0]        dv_ry_q  [0:QB];
  logic [QB-1:0]        dv_ly_q  [0:QB];
  logic [MW-1:0]        dv_den_q [0:QB];
  logic                 dv_hit_q [0:QB];
  logic                 dv_par_q [0:QB];
  logic                 dv_negx_q[0:QB];
  logic                 dv_negy_q[0:QB];
  logic signed [CW-1:0] dv_bx_q  [0:QB];
  logic signed [CW-1:0] dv_by_q  [0:QB];

  // the quotient is known to fit QB bits, so the upper dividend bits start as remainder
  always_ff @(posedge clk_i) begin
    if (rdy[ST_DIV0]) begin
      dv_rx_q[0]   <= dvx[DVW-1:QB];
      dv_lx_q[0]   <= dvx[QB-1:0];
      dv_ry_q[0]   <= dvy[DVW-1:QB];
      dv_ly_q[0]   <= dvy[QB-1:0];
      dv_den_q[0]  <= s4_den_q;
      dv_hit_q[0]  <= s4_hit_q;
      dv_par_q[0]  <= s4_par_q;
      dv_negx_q[0] <= s4_negx_q;
      dv_negy_q[0] <= s4_negy_q;
      dv_bx_q[0]   <= s4_bx_q;
      dv_by_q[0]   <= s4_by_q;
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_div
    logic [MW:0] tx, ty, subx, suby, dext;
    logic        gex, gey;

    assign dext = {1'b0, dv_den_q[j-1]};
    assign tx   = {dv_rx_q[j-1], dv_lx_q[j-1][QB-1]};
    assign ty   = {dv_ry_q[j-1], dv_ly_q[j-1][QB-1]};
    assign gex  = (tx >= dext);
    assign gey  = (ty >= dext);
    assign subx = tx - dext;
    assign suby = ty - dext;

    always_ff @(posedge clk_i) begin
      if (rdy[ST_DIV0+j]) begin
        dv_rx_q[j]   <= gex ? subx[MW-1:0] : tx[MW-1:0];
        dv_ry_q[j]   <= gey ? suby[MW-1:0] : ty[MW-1:0];
        // quotient bits fill in as dividend bits shift out
        dv_lx_q[j]   <= {dv_lx_q[j-1][QB-2:0], gex};
        dv_ly_q[j]   <= {dv_ly_q[j-1][QB-2:0], gey};
        dv_den_q[j]  <= dv_den_q[j-1];
        dv_hit_q[j]  <= dv_hit_q[j-1];
        dv_par_q[j]  <= dv_par_q[j-1];
        dv_negx_q[j] <= dv_negx_q[j-1];
        dv_negy_q[j] <= dv_negy_q[j-1];
        dv_bx_q[j]   <= dv_bx_q[j-1];
        dv_by_q[j]   <= dv_by_q[j-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // post stage a: base plus floor of the signed offset
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] bx2, by2, qx_s, qy_s, rx_s, ry_s;
  logic                 remx, remy;

  assign remx = (dv_rx_q[QB] != '0);
  assign remy = (dv_ry_q[QB] != '0);
  assign bx2  = SW'(dv_bx_q[QB]) <<< FRAC;
  assign by2  = SW'(dv_by_q[QB]) <<< FRAC;
  assign qx_s = signed'(SW'(dv_lx_q[QB]));
  assign qy_s = signed'(SW'(dv_ly_q[QB]));
  assign rx_s = signed'(SW'(remx));
  assign ry_s = signed'(SW'(remy));

  logic signed [SW-1:0] pa_x_q, pa_y_q;
  logic                 pa_remx_q, pa_remy_q, pa_zero_q, pa_hit_q, pa_par_q;

  always_ff @(posedge clk_i) begin
    if (rdy[ST_PA]) begin
      pa_x_q    <= dv_negx_q[QB] ? (bx2 - qx_s - rx_s) : (bx2 + qx_s);
      pa_y_q    <= dv_negy_q[QB] ? (by2 - qy_s - ry_s) : (by2 + qy_s);
      pa_remx_q <= remx;
      pa_remy_q <= remy;
      pa_zero_q <= ~dv_hit_q[QB] | dv_par_q[QB];
      pa_hit_q  <= dv_hit_q[QB];
      pa_par_q  <= dv_par_q[QB];
    end
  end

  // ---------------------------------------------------------------------------
  // post stage b: floor to truncation, saturate, output register
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] tx_c, ty_c;
  logic signed [EW-1:0] ex, ey;
  logic signed [OUT_W-1:0] satx, saty;

  assign tx_c = (pa_x_q[SW-1] && pa_remx_q) ? pa_x_q + SW'(1) : pa_x_q;
  assign ty_c = (pa_y_q[SW-1] && pa_remy_q) ? pa_y_q + SW'(1) : pa_y_q;
  assign ex   = EW'(tx_c);
  assign ey   = EW'(ty_c);

  always_comb begin
    if (ex > EW'(OUT_MAX)) begin
      satx = OUT_W'(OUT_MAX);
    end else if (ex < EW'(OUT_MIN)) begin
      satx = OUT_W'(OUT_MIN);
    end else begin
      satx = ex[OUT_W-1:0];
    end
    if (ey > EW'(OUT_MAX)) begin
      saty = OUT_W'(OUT_MAX);
    end else if (ey < EW'(OUT_MIN)) begin
      saty = OUT_W'(OUT_MIN);
    end else begin
      saty = ey[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_PB]) begin
      point_x_o  <= pa_zero_q ? '0 : satx;
      point_y_o  <= pa_zero_q ? '0 : saty;
      hit_o      <= pa_hit_q;
      parallel_o <= pa_par_q;
    end
  end

endmodule
